// ----- hw/rtl/qmm_pkg.sv -----
package qmm_pkg;

	localparam int DEM_W      = 16;
	localparam int PULSE_W    = 13;
	localparam int CFG_W      = 12;
	localparam int GAIN_W     = 10;
	localparam int CFG_IDX_W  = 2;
	localparam int ACT_W      = 2;
	localparam int OFF_W      = 12;
	localparam int PROD_W     = DEM_W + GAIN_W;
	localparam int THR_PROD_W = 30;
	localparam int MOTORS     = 4;

	localparam logic [CFG_IDX_W-1:0] CFG_MIN_PULSE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_PULSE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RP_GAIN   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_YAW_GAIN  = 2'd3;

	localparam logic [CFG_W-1:0]  MIN_PULSE_RST = 12'd1000;
	localparam logic [CFG_W-1:0]  MAX_PULSE_RST = 12'd2000;
	localparam logic [GAIN_W-1:0] RP_GAIN_RST   = 10'd100;
	localparam logic [GAIN_W-1:0] YAW_GAIN_RST  = 10'd50;

	localparam logic [ACT_W-1:0] ACT_HOLD = 2'd0;
	localparam logic [ACT_W-1:0] ACT_CUT  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_MIX  = 2'd2;

	localparam logic [DEM_W-1:0] DEMAND_FULL = 16'd25600;

	// floor(u/100) for u below 2**22, exact reciprocal
	localparam logic [22:0] DIV100_MUL    = 23'd5368710;
	localparam logic [21:0] DIV100_BIAS   = 22'd1638400;
	localparam logic [16:0] DIV100_BIAS_Q = 17'd16384;

	// floor(a/3) for a below 2**14
	localparam logic [14:0] DIV3_MUL = 15'd21846;

	// bit m set: axis enters motor m negated (fl, fr, bl, br)
	localparam logic [MOTORS-1:0] ROLL_NEG  = 4'b1010;
	localparam logic [MOTORS-1:0] PITCH_NEG = 4'b0011;
	localparam logic [MOTORS-1:0] YAW_NEG   = 4'b0110;

	typedef struct packed {
		logic [ACT_W-1:0] act;
		logic             thr;
		logic [1:0]       naxes;
	} ctl_t;

	function automatic logic [15:0] div100_f(input logic [21:0] u);
		logic [44:0] prod;
		prod = 45'(u) * 45'(DIV100_MUL);
		return prod[44:29];
	endfunction

endpackage

// ----- hw/rtl/qmm_if.sv -----
interface qmm_demand_if;
	import qmm_pkg::*;
	logic             valid;
	logic             ready;
	logic [DEM_W-1:0] throttle_demand;
	logic [DEM_W-1:0] roll_demand;
	logic [DEM_W-1:0] pitch_demand;
	logic [DEM_W-1:0] yaw_demand;

	modport source (
		output valid, throttle_demand, roll_demand, pitch_demand, yaw_demand,
		input  ready
	);
	modport sink (
		input  valid, throttle_demand, roll_demand, pitch_demand, yaw_demand,
		output ready
	);
endinterface

interface qmm_result_if;
	import qmm_pkg::*;
	logic                      valid;
	logic                      ready;
	logic [ACT_W-1:0]          action;
	logic signed [PULSE_W-1:0] front_left_pulse;
	logic signed [PULSE_W-1:0] front_right_pulse;
	logic signed [PULSE_W-1:0] back_left_pulse;
	logic signed [PULSE_W-1:0] back_right_pulse;

	modport source (
		output valid, action, front_left_pulse, front_right_pulse,
		       back_left_pulse, back_right_pulse,
		input  ready
	);
	modport sink (
		input  valid, action, front_left_pulse, front_right_pulse,
		       back_left_pulse, back_right_pulse,
		output ready
	);
endinterface

// ----- hw/rtl/qmm_prod.sv -----
module qmm_prod (
	input  logic                              clk,
	input  logic                              en,
	input  logic [qmm_pkg::DEM_W-1:0]         thr_d_s1,
	input  logic [qmm_pkg::DEM_W-1:0]         roll_d_s1,
	input  logic [qmm_pkg::DEM_W-1:0]         pitch_d_s1,
	input  logic [qmm_pkg::DEM_W-1:0]         yaw_d_s1,
	input  logic [qmm_pkg::CFG_W-1:0]         min_pulse,
	input  logic [qmm_pkg::CFG_W-1:0]         max_pulse,
	input  logic [qmm_pkg::GAIN_W-1:0]        rp_gain,
	input  logic [qmm_pkg::GAIN_W-1:0]        yaw_gain,
	output qmm_pkg::ctl_t                     ctl_s2,
	output logic [qmm_pkg::PROD_W-1:0]        roll_p_s2,
	output logic [qmm_pkg::PROD_W-1:0]        pitch_p_s2,
	output logic [qmm_pkg::PROD_W-1:0]        yaw_p_s2,
	output logic signed [qmm_pkg::THR_PROD_W-1:0] thr_p_s2
);
	import qmm_pkg::*;

	ctl_t                         ctl;
	logic                         bad;
	logic                         roll_nz, pitch_nz, yaw_nz;
	logic signed [CFG_W:0]        span;
	logic signed [DEM_W:0]        t_sx;
	logic signed [THR_PROD_W-1:0] thr_p;
	logic [PROD_W-1:0]            roll_p, pitch_p, yaw_p;

	always_comb begin
		bad = (thr_d_s1 > DEMAND_FULL) || (roll_d_s1 > DEMAND_FULL) ||
		      (pitch_d_s1 > DEMAND_FULL) || (yaw_d_s1 > DEMAND_FULL);
		roll_nz  = roll_d_s1 != '0;
		pitch_nz = pitch_d_s1 != '0;
		yaw_nz   = yaw_d_s1 != '0;
		ctl.thr   = thr_d_s1 != '0;
		ctl.naxes = {1'b0, roll_nz} + {1'b0, pitch_nz} + {1'b0, yaw_nz};
		if (bad || (!ctl.thr && ctl.naxes == 2'd3)) begin
			ctl.act = ACT_HOLD;
		end else if (!ctl.thr && ctl.naxes == 2'd0) begin
			ctl.act = ACT_CUT;
		end else begin
			ctl.act = ACT_MIX;
		end

		span    = $signed({1'b0, max_pulse}) - $signed({1'b0, min_pulse});
		t_sx    = $signed({1'b0, thr_d_s1});
		thr_p   = THR_PROD_W'(t_sx) * THR_PROD_W'(span);
		roll_p  = PROD_W'(roll_d_s1) * PROD_W'(rp_gain);
		pitch_p = PROD_W'(pitch_d_s1) * PROD_W'(rp_gain);
		yaw_p   = PROD_W'(yaw_d_s1) * PROD_W'(yaw_gain);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s2     <= ctl;
			roll_p_s2  <= roll_p;
			pitch_p_s2 <= pitch_p;
			yaw_p_s2   <= yaw_p;
			thr_p_s2   <= thr_p;
		end
	end

endmodule

// ----- hw/rtl/qmm_scale.sv -----
module qmm_scale (
	input  logic                                  clk,
	input  logic                                  en,
	input  qmm_pkg::ctl_t                         ctl_s2,
	input  logic [qmm_pkg::PROD_W-1:0]            roll_p_s2,
	input  logic [qmm_pkg::PROD_W-1:0]            pitch_p_s2,
	input  logic [qmm_pkg::PROD_W-1:0]            yaw_p_s2,
	input  logic signed [qmm_pkg::THR_PROD_W-1:0] thr_p_s2,
	input  logic [qmm_pkg::CFG_W-1:0]             min_pulse,
	output qmm_pkg::ctl_t                         ctl_s3,
	output logic [qmm_pkg::OFF_W-1:0]             roll_off_s3,
	output logic [qmm_pkg::OFF_W-1:0]             pitch_off_s3,
	output logic [qmm_pkg::OFF_W-1:0]             yaw_off_s3,
	output logic [qmm_pkg::CFG_W-1:0]             thr_s3
);
	import qmm_pkg::*;

	logic [21:0]        tu;
	logic [15:0]        tq;
	logic signed [16:0] tfl;
	logic signed [17:0] tsum;
	logic [CFG_W-1:0]   thr;
	logic [15:0]        roll_q, pitch_q, yaw_q;

	always_comb begin
		// floor of a signed value by 25600: arithmetic shift, then biased floor by 100
		tu   = thr_p_s2[THR_PROD_W-1:8] + DIV100_BIAS;
		tq   = div100_f(tu);
		tfl  = $signed({1'b0, tq}) - $signed(DIV100_BIAS_Q);
		tsum = 18'(tfl) + $signed({6'b0, min_pulse});
		if (tsum < 0) begin
			thr = '0;
		end else if (tsum > 18'sd4095) begin
			thr = '1;
		end else begin
			thr = tsum[CFG_W-1:0];
		end
		roll_q  = div100_f({4'b0, roll_p_s2[PROD_W-1:8]});
		pitch_q = div100_f({4'b0, pitch_p_s2[PROD_W-1:8]});
		yaw_q   = div100_f({4'b0, yaw_p_s2[PROD_W-1:8]});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s3       <= ctl_s2;
			roll_off_s3  <= roll_q[OFF_W-1:0];
			pitch_off_s3 <= pitch_q[OFF_W-1:0];
			yaw_off_s3   <= yaw_q[OFF_W-1:0];
			thr_s3       <= thr;
		end
	end

endmodule

// ----- hw/rtl/qmm_mix.sv -----
module qmm_mix (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  qmm_pkg::ctl_t                    ctl_s3,
	input  logic [qmm_pkg::OFF_W-1:0]        roll_off_s3,
	input  logic [qmm_pkg::OFF_W-1:0]        pitch_off_s3,
	input  logic [qmm_pkg::OFF_W-1:0]        yaw_off_s3,
	input  logic [qmm_pkg::CFG_W-1:0]        thr_s3,
	output logic [qmm_pkg::ACT_W-1:0]        action_q,
	output logic signed [qmm_pkg::PULSE_W-1:0] pulse_q [qmm_pkg::MOTORS]
);
	import qmm_pkg::*;

	logic [CFG_W-1:0]          base_q;
	logic [CFG_W-1:0]          base_new;
	logic signed [PULSE_W-1:0] mix [MOTORS];

	always_comb begin
		logic signed [14:0] r, p, y;
		logic signed [14:0] sum;
		logic [13:0]        mag;
		logic [28:0]        prod3;
		logic [12:0]        qmag;
		logic signed [14:0] qs;
		logic signed [16:0] tot;
		base_new = (ctl_s3.thr && (ctl_s3.naxes != 2'd0 || thr_s3 != '0)) ? thr_s3 : base_q;
		r = $signed({3'b0, roll_off_s3});
		p = $signed({3'b0, pitch_off_s3});
		y = $signed({3'b0, yaw_off_s3});
		for (int m = 0; m < MOTORS; m++) begin
			sum = (ROLL_NEG[m] ? -r : r) + (PITCH_NEG[m] ? -p : p) + (YAW_NEG[m] ? -y : y);
			mag = sum[14] ? 14'(-sum) : 14'(sum);
			prod3 = 29'(mag) * 29'(DIV3_MUL);
			case (ctl_s3.naxes)
				2'd1: qmag = mag[12:0];
				2'd2: qmag = mag[13:1];
				2'd3: qmag = prod3[28:16];
				default: qmag = '0;
			endcase
			qs  = sum[14] ? -$signed({2'b0, qmag}) : $signed({2'b0, qmag});
			tot = $signed({5'b0, base_new}) + 17'(qs);
			if (tot > 17'sd4095) begin
				mix[m] = 13'sd4095;
			end else if (tot < -17'sd4096) begin
				mix[m] = -13'sd4096;
			end else begin
				mix[m] = tot[PULSE_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			action_q <= ACT_HOLD;
			base_q   <= '0;
			for (int m = 0; m < MOTORS; m++) pulse_q[m] <= '0;
		end else if (en) begin
			action_q <= ctl_s3.act;
			case (ctl_s3.act)
				ACT_MIX: begin
					base_q <= base_new;
					for (int m = 0; m < MOTORS; m++) pulse_q[m] <= mix[m];
				end
				ACT_CUT: begin
					for (int m = 0; m < MOTORS; m++) pulse_q[m] <= '0;
				end
				default: ;
			endcase
		end
	end

`ifndef SYNTH
	a_hold_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		en && ctl_s3.act == ACT_HOLD |=> $stable(base_q) && $stable(pulse_q[0]) &&
		$stable(pulse_q[1]) && $stable(pulse_q[2]) && $stable(pulse_q[3]))
		else $error("hold beat changed motor state");
	a_cut_zero: assert property (@(posedge clk) disable iff (!arst_n)
		en && ctl_s3.act == ACT_CUT |=> $stable(base_q) && pulse_q[0] == '0 &&
		pulse_q[1] == '0 && pulse_q[2] == '0 && pulse_q[3] == '0)
		else $error("cut beat left pulses or touched base");
	a_idle_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(action_q) && $stable(base_q) && $stable(pulse_q[0]))
		else $error("mixer state moved without a beat");
`endif

endmodule

// ----- hw/rtl/quad_motor_mixer_top.sv -----
// channel  | dir | beat contents
// demand   | in  | throttle_demand, roll_demand, pitch_demand, yaw_demand
// result   | out | action, front_left_pulse, front_right_pulse,
//          |     | back_left_pulse, back_right_pulse
// cfg      | in  | cfg_we, cfg_index, cfg_data (write only)
//
// one beat per clock sustained while result.ready holds
// stages: input register, gain products, divide by 25600, axis mix into state
// arst_n clears valids, motor state and the config registers to their defaults
// each stage fills independently, so demand stays ready while a result waits
// until all four stages hold a beat
module quad_motor_mixer_top (
	input  logic                             clk,
	input  logic                             arst_n,
	qmm_demand_if.sink                       demand,
	qmm_result_if.source                     result,
	input  logic                             cfg_we,
	input  logic [qmm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [qmm_pkg::CFG_W-1:0]        cfg_data
);
	import qmm_pkg::*;

	logic [CFG_W-1:0]  min_pulse_q, max_pulse_q;
	logic [GAIN_W-1:0] rp_gain_q, yaw_gain_q;

	logic v1_q, v2_q, v3_q, ov_q;
	logic r_out, r3, r2, r1;
	logic en1, en2, en3, en4;

	logic [DEM_W-1:0] thr_d_s1, roll_d_s1, pitch_d_s1, yaw_d_s1;

	ctl_t                         ctl_s2, ctl_s3;
	logic [PROD_W-1:0]            roll_p_s2, pitch_p_s2, yaw_p_s2;
	logic signed [THR_PROD_W-1:0] thr_p_s2;
	logic [OFF_W-1:0]             roll_off_s3, pitch_off_s3, yaw_off_s3;
	logic [CFG_W-1:0]             thr_s3;
	logic [ACT_W-1:0]             action_q;
	logic signed [PULSE_W-1:0]    pulse_q [MOTORS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_pulse_q <= MIN_PULSE_RST;
			max_pulse_q <= MAX_PULSE_RST;
			rp_gain_q   <= RP_GAIN_RST;
			yaw_gain_q  <= YAW_GAIN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MIN_PULSE: min_pulse_q <= cfg_data;
				CFG_MAX_PULSE: max_pulse_q <= cfg_data;
				CFG_RP_GAIN:   rp_gain_q   <= cfg_data[GAIN_W-1:0];
				CFG_YAW_GAIN:  yaw_gain_q  <= cfg_data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	assign r_out = !ov_q || result.ready;
	assign r3    = !v3_q || r_out;
	assign r2    = !v2_q || r3;
	assign r1    = !v1_q || r2;
	assign en1   = demand.valid && r1;
	assign en2   = v1_q && r2;
	assign en3   = v2_q && r3;
	assign en4   = v3_q && r_out;

	assign demand.ready = r1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			v1_q <= en1 || (v1_q && !r2);
			v2_q <= en2 || (v2_q && !r3);
			v3_q <= en3 || (v3_q && !r_out);
			ov_q <= en4 || (ov_q && !result.ready);
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			thr_d_s1   <= demand.throttle_demand;
			roll_d_s1  <= demand.roll_demand;
			pitch_d_s1 <= demand.pitch_demand;
			yaw_d_s1   <= demand.yaw_demand;
		end
	end

	qmm_prod u_prod (
		.clk        (clk),
		.en         (en2),
		.thr_d_s1   (thr_d_s1),
		.roll_d_s1  (roll_d_s1),
		.pitch_d_s1 (pitch_d_s1),
		.yaw_d_s1   (yaw_d_s1),
		.min_pulse  (min_pulse_q),
		.max_pulse  (max_pulse_q),
		.rp_gain    (rp_gain_q),
		.yaw_gain   (yaw_gain_q),
		.ctl_s2     (ctl_s2),
		.roll_p_s2  (roll_p_s2),
		.pitch_p_s2 (pitch_p_s2),
		.yaw_p_s2   (yaw_p_s2),
		.thr_p_s2   (thr_p_s2)
	);

	qmm_scale u_scale (
		.clk          (clk),
		.en           (en3),
		.ctl_s2       (ctl_s2),
		.roll_p_s2    (roll_p_s2),
		.pitch_p_s2   (pitch_p_s2),
		.yaw_p_s2     (yaw_p_s2),
		.thr_p_s2     (thr_p_s2),
		.min_pulse    (min_pulse_q),
		.ctl_s3       (ctl_s3),
		.roll_off_s3  (roll_off_s3),
		.pitch_off_s3 (pitch_off_s3),
		.yaw_off_s3   (yaw_off_s3),
		.thr_s3       (thr_s3)
	);

	qmm_mix u_mix (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en4),
		.ctl_s3       (ctl_s3),
		.roll_off_s3  (roll_off_s3),
		.pitch_off_s3 (pitch_off_s3),
		.yaw_off_s3   (yaw_off_s3),
		.thr_s3       (thr_s3),
		.action_q     (action_q),
		.pulse_q      (pulse_q)
	);

	assign result.valid             = ov_q;
	assign result.action            = action_q;
	assign result.front_left_pulse  = pulse_q[0];
	assign result.front_right_pulse = pulse_q[1];
	assign result.back_left_pulse   = pulse_q[2];
	assign result.back_right_pulse  = pulse_q[3];

endmodule
